### sv/assert_macros.svh
// Concurrent assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### sv/dbbe_pkg.sv
`default_nettype none
package dbbe_pkg;

	localparam int WORD_BITS = 64;
	localparam int MAX_WORDS = 16;

	localparam int PLANE_W    = 64;
	localparam int NUM_PLANES = 5;
	localparam int CHAR_W     = 8;
	localparam int IDX_W      = 4;
	localparam int BP_W       = $clog2(WORD_BITS);

	localparam int CNT_MAX_I  = (MAX_WORDS - 1 > 15) ? 15 : MAX_WORDS - 1;
	localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(CNT_MAX_I);

	localparam int PLANE_A = 0;
	localparam int PLANE_C = 1;
	localparam int PLANE_G = 2;
	localparam int PLANE_T = 3;
	localparam int PLANE_N = 4;

	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;

	localparam int OUT_RAW_W  = NUM_PLANES * PLANE_W + IDX_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

	typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] planes_t;

	typedef struct packed {
		logic                  valid;
		logic [NUM_PLANES-1:0] code_oh;
		logic                  last;
	} step_t;

	typedef struct packed {
		planes_t          planes;
		logic [IDX_W-1:0] word_index;
		logic             last_word;
	} result_t;

endpackage
`default_nettype wire

### sv/dna_base_bitplane_encoder_core.sv
`default_nettype none
// Bit-plane encoder for DNA reads. One character enters per cycle on s_axis and is
// mapped to A, C, G, T or N (any other byte counts as A); bit k of that base's 64-bit
// plane is set for the k-th character of the current word. A word holds 64 characters
// when full_word is 1 and 63 when it is 0. When a word fills, or on the character that
// carries tlast, all five planes leave on m_axis together with the word index within
// the read (saturating at 15) and tlast marking the read's final word. The plane
// update and word-end test sit between the plane registers and a single output
// register, so a new character is taken every cycle as long as the output register
// is empty or being drained. cfg is always ready and must only be written while the
// block is idle.
module dna_base_bitplane_encoder_core
	import dbbe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,       // full_word
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [CHAR_W-1:0]     s_axis_tdata,   // base_char[7:0]
	input  wire logic                  s_axis_tlast,   // read_end
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// a_bits, c_bits, g_bits, t_bits, n_bits, word_index, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast    // last_word
);

	logic                  full_word_q;
	logic                  out_valid_q;
	result_t               out_q;
	logic [NUM_PLANES-1:0] code_oh;
	step_t                 step;
	logic                  emit;
	result_t               result;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	assign step = '{valid: s_axis_tvalid && s_axis_tready, code_oh: code_oh,
		last: s_axis_tlast};

	dbbe_decode u_decode (
		.base_char (s_axis_tdata),
		.code_oh   (code_oh)
	);

	dbbe_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.full_word (full_word_q),
		.step      (step),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_word_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			full_word_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.word_index, out_q.planes};
	assign m_axis_tlast  = out_q.last_word;

endmodule
`default_nettype wire

### sv/dbbe_decode.sv
`default_nettype none
module dbbe_decode
	import dbbe_pkg::*;
(
	input  wire logic [CHAR_W-1:0]     base_char,
	output logic      [NUM_PLANES-1:0] code_oh
);

	always_comb begin
		code_oh = '0;
		unique case (base_char)
			CHAR_C:  code_oh[PLANE_C] = 1'b1;
			CHAR_G:  code_oh[PLANE_G] = 1'b1;
			CHAR_T:  code_oh[PLANE_T] = 1'b1;
			CHAR_N:  code_oh[PLANE_N] = 1'b1;
			default: code_oh[PLANE_A] = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

### sv/dbbe_accum.sv
`default_nettype none
`include "assert_macros.svh"
module dbbe_accum
	import dbbe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    full_word,
	input  wire step_t   step,
	output logic         emit,
	output result_t      result
);

	planes_t          planes_q;
	planes_t          planes_next;
	logic [BP_W-1:0]  bp_q;
	logic [BP_W:0]    bp_inc;
	logic [BP_W:0]    size;
	logic [IDX_W-1:0] wc_q;

	assign size   = full_word ? (BP_W+1)'(WORD_BITS) : (BP_W+1)'(WORD_BITS - 1);
	assign bp_inc = {1'b0, bp_q} + (BP_W+1)'(1);
	assign emit   = step.valid && (step.last || (bp_inc >= size));

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			planes_next[p] = planes_q[p] |
				(step.code_oh[p] ? (PLANE_W'(1) << bp_q) : '0);
		end
	end

	assign result.planes     = planes_next;
	assign result.word_index = wc_q;
	assign result.last_word  = step.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
			bp_q     <= '0;
			wc_q     <= '0;
		end else if (step.valid) begin
			if (emit) begin
				planes_q <= '0;
				bp_q     <= '0;
				if (step.last) begin
					wc_q <= '0;
				end else if (wc_q < CNT_MAX) begin
					wc_q <= wc_q + IDX_W'(1);
				end
			end else begin
				planes_q <= planes_next;
				bp_q     <= bp_inc[BP_W-1:0];
			end
		end
	end

	`ASSERT_CLK(a_code_onehot, clk, arst_n, step.valid |-> $onehot(step.code_oh), "code not one-hot")
	`ASSERT_CLK(a_bp_range, clk, arst_n, {1'b0, bp_q} < size || !full_word, "bit position past word")
	`ASSERT_CLK(a_emit_clears, clk, arst_n, emit |=> (bp_q == '0 && planes_q == '0), "word not cleared")
	`ASSERT_CLK(a_last_resets, clk, arst_n, (step.valid && step.last) |=> wc_q == '0, "counter kept")
	`ASSERT_CLK(a_wc_max, clk, arst_n, wc_q <= CNT_MAX, "word counter above max")

endmodule
`default_nettype wire

### tb/tb_dna_base_bitplane_encoder_core.sv
module tb_dna_base_bitplane_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dbbe_pkg::*;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int CFG_SETTLE      = 4;
	localparam int DRAIN_CYCLES    = 8;

	typedef enum logic {ROW_CHARS, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CHAR_W-1:0] ch;
		logic              read_end;
		int                reps;
		bit                typed;
		int                exp_plane;
		logic [63:0]       exp_bits;
		logic [IDX_W-1:0]  exp_idx;
		logic              exp_last;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	planes_t          plane_acc = '0;
	logic [6:0]       char_pos = '0;
	logic [IDX_W-1:0] word_cnt = '0;
	logic             full_word_cfg = 1'b0;

	result_t   pending_words[$];
	stim_row_t dir_rows[$];
	logic [CHAR_W-1:0] letters [5];
	result_t   mon_got;
	result_t   mon_want;
	int        fail_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	bit        hold_req = 1'b0;
	int        quiet_cycles = 0;

	dna_base_bitplane_encoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic bit encode_char(input logic [CHAR_W-1:0] ch, input logic read_end,
			output result_t word);
		int code;
		logic [6:0] size;
		case (ch)
			CHAR_C: code = PLANE_C;
			CHAR_G: code = PLANE_G;
			CHAR_T: code = PLANE_T;
			CHAR_N: code = PLANE_N;
			default: code = PLANE_A;
		endcase
		size = full_word_cfg ? 7'(WORD_BITS) : 7'(WORD_BITS - 1);
		plane_acc[code][char_pos[5:0]] = 1'b1;
		char_pos = char_pos + 7'd1;
		word = '0;
		if (!(read_end || char_pos >= size))
			return 1'b0;
		word.planes = plane_acc;
		word.word_index = word_cnt;
		word.last_word = read_end;
		plane_acc = '0;
		char_pos = '0;
		if (read_end)
			word_cnt = '0;
		else if (word_cnt < CNT_MAX)
			word_cnt = word_cnt + 1'b1;
		return 1'b1;
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic [CHAR_W-1:0] ch,
			input logic read_end, input int reps, input bit typed, input int exp_plane,
			input logic [63:0] exp_bits, input logic [IDX_W-1:0] exp_idx, input logic exp_last);
		stim_row_t row;
		row.kind = kind;
		row.ch = ch;
		row.read_end = read_end;
		row.reps = reps;
		row.typed = typed;
		row.exp_plane = exp_plane;
		row.exp_bits = exp_bits;
		row.exp_idx = exp_idx;
		row.exp_last = exp_last;
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic read_end, input bit typed,
			input result_t known);
		result_t word;
		bit emitted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= read_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		emitted = encode_char(ch, read_end, word);
		if (typed)
			pending_words.push_back(known);
		else if (emitted)
			pending_words.push_back(word);
		@(negedge clk);
	endtask

	task automatic write_full_word(input logic value);
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		full_word_cfg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off the output for a long stretch on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			for (int i = 0; i < NUM_PLANES; i++)
				mon_got.planes[i] = m_axis_tdata[i*PLANE_W +: PLANE_W];
			mon_got.word_index = m_axis_tdata[NUM_PLANES*PLANE_W +: IDX_W];
			mon_got.last_word = m_axis_tlast;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, index", 64'(mon_got.word_index), '0);
			end else begin
				mon_want = pending_words.pop_front();
				for (int i = 0; i < NUM_PLANES; i++)
					if (mon_got.planes[i] !== mon_want.planes[i])
						report_mismatch($sformatf("plane %0d", i), mon_got.planes[i],
							mon_want.planes[i]);
				if (mon_got.word_index !== mon_want.word_index)
					report_mismatch("word_index", 64'(mon_got.word_index),
						64'(mon_want.word_index));
				if (mon_got.last_word !== mon_want.last_word)
					report_mismatch("last_word", 64'(mon_got.last_word), 64'(mon_want.last_word));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		result_t known;
		int phase;
		int items;
		int len;
		int pick;
		int wsize;
		logic [CHAR_W-1:0] ch;

		letters[0] = CHAR_A;
		letters[1] = CHAR_C;
		letters[2] = CHAR_G;
		letters[3] = CHAR_T;
		letters[4] = CHAR_N;

		add_row(ROW_CFG,   8'h00,  1'b0, 0,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_A, 1'b1, 1,  1'b1, PLANE_A, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, CHAR_C, 1'b1, 1,  1'b1, PLANE_C, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, CHAR_G, 1'b1, 1,  1'b1, PLANE_G, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, CHAR_T, 1'b1, 1,  1'b1, PLANE_T, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, CHAR_N, 1'b1, 1,  1'b1, PLANE_N, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, 8'h00,  1'b1, 1,  1'b1, PLANE_A, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, 8'hFF,  1'b1, 1,  1'b1, PLANE_A, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, 8'h61,  1'b1, 1,  1'b1, PLANE_A, 64'd1, 4'd0, 1'b1);
		add_row(ROW_CHARS, CHAR_T, 1'b0, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_G, 1'b0, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_C, 1'b1, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_N, 1'b0, 63, 1'b1, PLANE_N, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
		add_row(ROW_CHARS, CHAR_C, 1'b1, 1,  1'b1, PLANE_C, 64'd1, 4'd1, 1'b1);
		add_row(ROW_CHARS, CHAR_G, 1'b0, 62, 1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_T, 1'b1, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_T, 1'b0, 63*17, 1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_G, 1'b1, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CFG,   8'h01,  1'b0, 0,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_C, 1'b0, 64, 1'b1, PLANE_C, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
		add_row(ROW_CHARS, CHAR_A, 1'b1, 1,  1'b1, PLANE_A, 64'd1, 4'd1, 1'b1);
		add_row(ROW_CHARS, CHAR_G, 1'b0, 63, 1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CFG,   8'h00,  1'b0, 0,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_T, 1'b0, 1,  1'b0, PLANE_A, '0, '0, 1'b0);
		add_row(ROW_CHARS, CHAR_N, 1'b1, 1,  1'b0, PLANE_A, '0, '0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 79;
		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			if (row.kind == ROW_CFG) begin
				write_full_word(row.ch[0]);
			end else begin
				known = '0;
				known.planes[row.exp_plane] = row.exp_bits;
				known.word_index = row.exp_idx;
				known.last_word = row.exp_last;
				for (int k = 0; k < row.reps; k++)
					send_char(row.ch, row.read_end, row.typed && (k == row.reps - 1), known);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_full_word(1'b1);
					send_idle_pct = 9;
					recv_idle_pct = 79;
				end
				1: begin
					write_full_word(1'b0);
					send_idle_pct = 79;
					recv_idle_pct = 9;
				end
				default: begin
					write_full_word(1'b1);
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				wsize = full_word_cfg ? WORD_BITS : WORD_BITS - 1;
				if (pick < 55)
					len = $urandom_range(16, 1);
				else if (pick < 85)
					len = $urandom_range(200, 17);
				else
					len = wsize * $urandom_range(4, 1) + $urandom_range(2) - 1;
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(99) < 75)
						ch = letters[$urandom_range(4)];
					else
						ch = CHAR_W'($urandom_range(255));
					send_char(ch, k == len - 1, 1'b0, '0);
				end
				items += len;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
